FILE: hw/rtl/fbfl_pkg.sv
// Shared constants and types for the fixed block free-list allocator.
// Used by fbfl_pool_ram and fixed_block_free_list_allocator; depends on nothing.
package fbfl_pkg;

   // Pool geometry.
   localparam int MAX_BLOCKS   = 256;
   localparam int LINK_BYTES   = 8;
   localparam int HEADER_BYTES = 16;

   // Field widths.
   localparam int IDX_W    = 8;
   localparam int COUNT_W  = 9;
   localparam int ADDR_W   = 32;
   localparam int BYTES_W  = 16;
   localparam int STRIDE_W = 17;
   localparam int PROD_W   = IDX_W + STRIDE_W;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   // The link memory holds one entry per block.
   localparam int POOL_DEPTH = 2 ** IDX_W;
   localparam logic [COUNT_W-1:0] POOL_LIMIT =
      COUNT_W'((MAX_BLOCKS < POOL_DEPTH) ? MAX_BLOCKS : POOL_DEPTH);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY        = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT  = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_EXEC
   } state_type;

   // One link memory word: free flag and the next block on the free list.
   typedef struct packed {
      logic             free;
      logic [IDX_W-1:0] link;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } ram_wr_type;

endpackage

FILE: hw/rtl/fbfl_pool_ram.sv
// Link memory of the block pool: one write port, one registered read port.
// Depends on fbfl_pkg for the entry and write port types.
module fbfl_pool_ram
   import fbfl_pkg::*;
(
   input  logic             clock,
   input  ram_wr_type       wr,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [POOL_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fixed_block_free_list_allocator.sv
// Top level of the fixed-size block pool allocator with a LIFO free list.
// Depends on fbfl_pkg and fbfl_pool_ram (free flags and links of all blocks).
//
//   channel   direction  handshake             payload
//   req_      in         req_tvalid/tready     op, block_index
//   rsp_      out        rsp_tvalid/tready     status, block_address, alloc_index, free_count
//   csr_      in         csr_valid/ready       csr_index, csr_data
//
// Allocate and free: the link memory is read when the item is accepted, and the entry
// is written back with the result once the output register is free to take it.
// Init sweeps a pool of n blocks with one link memory write per block.
// After reset the pool is empty until an init; there is no clearing pass.
// A result waiting in the output register holds the block in its final step.
module fixed_block_free_list_allocator
   import fbfl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [1:0] op, [9:2] block_index, rest zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [1:0] status, [33:2] block_address,
                                             // [41:34] alloc_index, [50:42] free_count
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   state_type state_ff, state_in;

   // Configuration registers.
   logic [ADDR_W-1:0]   base_ff;
   logic [BYTES_W-1:0]  bytes_ff;
   logic [COUNT_W-1:0]  count_ff;

   // Pool geometry captured at init.
   logic [COUNT_W-1:0]  pool_count_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [ADDR_W-1:0]   addr_base_ff;

   // Free list state.
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [COUNT_W-1:0]  free_blocks_ff, free_blocks_in;

   // Item in flight.
   logic [OP_W-1:0]     op_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    k_ff;
   logic [PROD_W-1:0]   prod_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [IDX_W-1:0]    rsp_aidx_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                req_accept;
   logic [OP_W-1:0]     req_op;
   logic [IDX_W-1:0]    req_idx;
   logic [COUNT_W-1:0]  init_count;
   logic [STRIDE_W-1:0] init_stride;
   logic [IDX_W-1:0]    last_k;
   logic                slot_free;
   logic                exec_commit;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   entry_type           rd_data;
   ram_wr_type          wr;
   ram_wr_type          exec_wr;
   logic [STATUS_W-1:0] exec_status;
   logic [ADDR_W-1:0]   exec_addr;
   logic [IDX_W-1:0]    exec_aidx;

   assign req_op     = req_tdata[1:0];
   assign req_idx    = req_tdata[9:2];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign exec_commit = (state_ff == S_EXEC) && slot_free;

   assign init_count  = (count_ff > POOL_LIMIT) ? POOL_LIMIT : count_ff;
   // Block size rounded as (bytes/4 + 1) * 4, plus the link word in front of each block.
   assign init_stride = (({3'b000, bytes_ff[BYTES_W-1:2]} + STRIDE_W'(1)) << 2)
                        + STRIDE_W'(LINK_BYTES);
   assign last_k      = IDX_W'(pool_count_ff - COUNT_W'(1));

   assign rd_en   = req_accept;
   assign rd_addr = (req_op == OP_ALLOC) ? head_ff : req_idx;

   fbfl_pool_ram u_pool_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_op == OP_INIT && init_count != '0) begin
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_SWEEP: begin
            if (k_ff == last_k) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result and write-back of the operation in its final step.
   always_comb begin
      exec_status    = ST_OK;
      exec_addr      = '0;
      exec_aidx      = '0;
      head_in        = head_ff;
      free_blocks_in = free_blocks_ff;
      exec_wr        = '0;
      case (op_ff)
         OP_INIT: begin
            head_in        = '0;
            free_blocks_in = pool_count_ff;
         end
         OP_ALLOC: begin
            if (free_blocks_ff == '0 || {1'b0, head_ff} >= pool_count_ff) begin
               exec_status = ST_EMPTY;
            end else begin
               exec_aidx           = head_ff;
               exec_addr           = addr_base_ff + ADDR_W'(prod_ff);
               exec_wr.en          = 1'b1;
               exec_wr.addr        = head_ff;
               exec_wr.data.free   = 1'b0;
               exec_wr.data.link   = rd_data.link;
               free_blocks_in      = free_blocks_ff - COUNT_W'(1);
               // The head goes back to block zero once the pool is drained.
               head_in = (free_blocks_ff == COUNT_W'(1)) ? '0 : rd_data.link;
            end
         end
         OP_FREE: begin
            if ({1'b0, idx_ff} >= pool_count_ff) begin
               exec_status = ST_RANGE;
            end else if (rd_data.free) begin
               exec_status = ST_ALREADY_FREE;
            end else begin
               exec_wr.en        = 1'b1;
               exec_wr.addr      = idx_ff;
               exec_wr.data.free = 1'b1;
               exec_wr.data.link = head_ff;
               head_in           = idx_ff;
               free_blocks_in    = free_blocks_ff + COUNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Link memory write: the init sweep chains blocks in order, otherwise the commit.
   always_comb begin
      wr = '0;
      if (state_ff == S_SWEEP) begin
         wr.en        = 1'b1;
         wr.addr      = k_ff;
         wr.data.free = 1'b1;
         wr.data.link = (k_ff == last_k) ? '0 : k_ff + IDX_W'(1);
      end else if (exec_commit) begin
         wr = exec_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         base_ff        <= '0;
         bytes_ff       <= BYTES_W'(4);
         count_ff       <= COUNT_W'(256);
         pool_count_ff  <= '0;
         stride_ff      <= '0;
         addr_base_ff   <= '0;
         head_ff        <= '0;
         free_blocks_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_ADDRESS: base_ff  <= csr_data;
               CSR_BLOCK_BYTES:  bytes_ff <= csr_data[BYTES_W-1:0];
               CSR_BLOCK_COUNT:  count_ff <= csr_data[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_accept && req_op == OP_INIT) begin
            pool_count_ff <= init_count;
            stride_ff     <= init_stride;
            addr_base_ff  <= base_ff + ADDR_W'(HEADER_BYTES + LINK_BYTES);
         end
         if (exec_commit) begin
            head_ff        <= head_in;
            free_blocks_ff <= free_blocks_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_op;
         idx_ff  <= req_idx;
         k_ff    <= '0;
         prod_ff <= PROD_W'(head_ff) * PROD_W'(stride_ff);
      end else if (state_ff == S_SWEEP) begin
         k_ff <= k_ff + IDX_W'(1);
      end
      if (exec_commit) begin
         rsp_status_ff <= exec_status;
         rsp_addr_ff   <= exec_addr;
         rsp_aidx_ff   <= exec_aidx;
         rsp_count_ff  <= free_blocks_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_count_ff, rsp_aidx_ff, rsp_addr_ff, rsp_status_ff};

   // While an init is in flight the new pool size is already captured but the free list
   // still describes the old pool, so the free list checks hold only between items.
`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> free_blocks_ff <= pool_count_ff)
      else $error("free block count exceeds pool size");

   a_head_in_pool: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && free_blocks_ff != '0 |-> {1'b0, head_ff} < pool_count_ff)
      else $error("free list head outside the pool");

   a_sweep_in_pool: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWEEP |-> {1'b0, k_ff} < pool_count_ff)
      else $error("init sweep beyond the pool");

   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      exec_commit |=> rsp_tvalid)
      else $error("committed item produced no result");

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      exec_commit && op_ff == OP_ALLOC && exec_status == ST_OK
      |=> free_blocks_ff == $past(free_blocks_ff) - COUNT_W'(1))
      else $error("allocation did not take exactly one block");
`endif

endmodule
